/* hdl/mvd_pkg.sv */
package mvd_pkg;

	localparam int FIELD_W    = 32;
	localparam int NCOEF      = 24;
	localparam int IDX_W      = 5;
	localparam int AMT_W      = 16;
	localparam int AMT_FRAC   = 14;
	localparam int AXIS_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int INV_BASE   = 12;

	typedef enum logic [1:0] {
		REQ_COEF    = 2'd0,
		REQ_MEASURE = 2'd1,
		REQ_DEFORM  = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMOUNT = 2'd0,
		CFG_SPREAD = 2'd1,
		CFG_AXIS   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FMAP,
		ST_MEAS,
		ST_CHECK,
		ST_DROP,
		ST_DIV,
		ST_HH,
		ST_HT,
		ST_HS,
		ST_SA,
		ST_SB,
		ST_SC,
		ST_IMAP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MA_COEF,
		MA_D,
		MA_H,
		MA_T,
		MA_G_A,
		MA_G_B
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_VEC,
		MB_AMT,
		MB_ONE_MINUS_H,
		MB_GAIN,
		MB_S
	} mul_b_t;

	typedef enum logic [2:0] {
		PO_NONE,
		PO_ACC_INIT,
		PO_ACC_ADD,
		PO_ACC_LAST,
		PO_DROP,
		PO_S,
		PO_G_A,
		PO_G_B
	} post_t;

	typedef struct packed {
		logic   load;
		logic   coef_wr;
		logic   meas;
		logic   check;
		logic   div_init;
		logic   div_step;
		logic   mul_en;
		mul_a_t mul_a;
		mul_b_t mul_b;
		post_t  post;
		logic   inv;
		logic [1:0] row;
		logic [1:0] col;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic d_le0;
		logic d_ge_span;
		logic gain_zero;
		logic out_full;
	} sts_t;

endpackage

/* hdl/mvd_req_if.sv */
interface mvd_req_if;
	import mvd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [IDX_W-1:0]          coef_index;
	logic signed [FIELD_W-1:0] coef_value;
	logic                      first_vertex;
	logic signed [FIELD_W-1:0] pos_x;
	logic signed [FIELD_W-1:0] pos_y;
	logic signed [FIELD_W-1:0] pos_z;

	modport source (
		output valid, req_type, coef_index, coef_value, first_vertex, pos_x, pos_y, pos_z,
		input  ready
	);
	modport sink (
		input  valid, req_type, coef_index, coef_value, first_vertex, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

/* hdl/mvd_res_if.sv */
interface mvd_res_if;
	import mvd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] out_x;
	logic signed [FIELD_W-1:0] out_y;
	logic signed [FIELD_W-1:0] out_z;

	modport source (output valid, out_x, out_y, out_z, input ready);
	modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

/* hdl/mvd_ctrl.sv */
module mvd_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_req,
	output logic          in_ready,
	input  mvd_pkg::sts_t sts,
	output mvd_pkg::cmd_t cmd
);
	import mvd_pkg::*;

	localparam int CNT_MAX = (FRAC_BITS > 12) ? FRAC_BITS : 12;
	localparam int CNT_W   = $clog2(CNT_MAX);
	localparam logic [CNT_W-1:0] MAP_LAST = CNT_W'(11);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             cnt_clr, cnt_inc;
	logic [1:0]       req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			req_q <= '0;
		end else begin
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (in_valid && in_ready) begin
				req_q <= in_req;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cnt_clr = 1'b0;
		cnt_inc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cnt_clr = 1'b1;
				if (in_valid) begin
					case (in_req)
						REQ_COEF: begin
							cmd.coef_wr = 1'b1;
						end
						REQ_MEASURE, REQ_DEFORM: begin
							cmd.load = 1'b1;
							state_d  = ST_FMAP;
						end
						default: begin
						end
					endcase
				end
			end
			ST_FMAP, ST_IMAP: begin
				cmd.inv    = (state_q == ST_IMAP);
				cmd.row    = cnt_q[3:2];
				cmd.col    = cnt_q[1:0];
				cmd.mul_en = (cnt_q[1:0] != 2'd3);
				cmd.mul_a  = MA_COEF;
				cmd.mul_b  = MB_VEC;
				case (cnt_q[1:0])
					2'd0:    cmd.post = PO_NONE;
					2'd1:    cmd.post = PO_ACC_INIT;
					2'd2:    cmd.post = PO_ACC_ADD;
					default: cmd.post = PO_ACC_LAST;
				endcase
				cnt_inc = 1'b1;
				if (cnt_q == MAP_LAST) begin
					cnt_clr = 1'b1;
					if (state_q == ST_IMAP) begin
						state_d = ST_OUT;
					end else if (req_q == REQ_MEASURE) begin
						state_d = ST_MEAS;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_MEAS: begin
				cmd.meas = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (sts.pass) begin
					state_d = ST_OUT;
				end else begin
					cmd.mul_en = 1'b1;
					cmd.mul_a  = MA_D;
					cmd.mul_b  = MB_AMT;
					state_d    = ST_DROP;
				end
			end
			ST_DROP: begin
				cmd.post     = PO_DROP;
				cmd.div_init = 1'b1;
				cnt_clr      = 1'b1;
				if (sts.gain_zero) begin
					state_d = ST_IMAP;
				end else if (sts.d_le0 || sts.d_ge_span) begin
					state_d = ST_HH;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_inc      = 1'b1;
				if (cnt_q == DIV_LAST) begin
					cnt_clr = 1'b1;
					state_d = ST_HH;
				end
			end
			ST_HH: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = MA_H;
				cmd.mul_b  = MB_ONE_MINUS_H;
				state_d    = ST_HT;
			end
			ST_HT: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = MA_T;
				cmd.mul_b  = MB_GAIN;
				state_d    = ST_HS;
			end
			ST_HS: begin
				cmd.post = PO_S;
				state_d  = ST_SA;
			end
			ST_SA: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = MA_G_A;
				cmd.mul_b  = MB_S;
				state_d    = ST_SB;
			end
			ST_SB: begin
				cmd.mul_en = 1'b1;
				cmd.mul_a  = MA_G_B;
				cmd.mul_b  = MB_S;
				cmd.post   = PO_G_A;
				state_d    = ST_SC;
			end
			ST_SC: begin
				cmd.post = PO_G_B;
				cnt_clr  = 1'b1;
				state_d  = ST_IMAP;
			end
			ST_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

/* hdl/mvd_datapath.sv */
module mvd_datapath #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mvd_pkg::cmd_t                       cmd,
	output mvd_pkg::sts_t                       sts,
	input  logic [mvd_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [mvd_pkg::FIELD_W-1:0]  coef_value,
	input  logic                                first_vertex,
	input  logic signed [mvd_pkg::FIELD_W-1:0]  pos_x,
	input  logic signed [mvd_pkg::FIELD_W-1:0]  pos_y,
	input  logic signed [mvd_pkg::FIELD_W-1:0]  pos_z,
	input  logic                                cfg_we,
	input  logic [mvd_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [mvd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mvd_pkg::FIELD_W-1:0]  out_x,
	output logic signed [mvd_pkg::FIELD_W-1:0]  out_y,
	output logic signed [mvd_pkg::FIELD_W-1:0]  out_z
);
	import mvd_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int MB  = (W > FIELD_W) ? W : FIELD_W;
	localparam int M   = ((MB > F + 3) ? MB : F + 3) + 2;
	localparam int PW  = 2 * M;
	localparam int AW  = PW + 2;
	localparam int THR_I = (2 ** F) / 10000;

	localparam logic [PW-1:0] HALF_F = PW'(1) << (F - 1);
	localparam logic [PW-1:0] HALF_A = PW'(1) << (AMT_FRAC - 1);
	localparam logic signed [W-1:0]  HI_W = signed'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [W-1:0]  LO_W = signed'({1'b1, {(W-1){1'b0}}});
	localparam logic signed [AW-1:0] HI_A = AW'(HI_W);
	localparam logic signed [AW-1:0] LO_A = AW'(LO_W);
	localparam logic signed [W:0]    THR  = (W+1)'(THR_I);
	localparam logic [F:0]           ONE_H = {1'b1, {F{1'b0}}};

	function automatic logic signed [W-1:0] clamp_w(input logic signed [AW-1:0] x);
		if (x > HI_A) begin
			return HI_W;
		end else if (x < LO_A) begin
			return LO_W;
		end
		return W'(x);
	endfunction

	// Round half away from zero after the shift.
	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
			input logic [PW-1:0] half, input logic sel_f);
		logic [PW-1:0] mag;
		logic [PW-1:0] q;
		mag = v[PW-1] ? $unsigned(-v) : $unsigned(v);
		q   = sel_f ? ((mag + half) >> F) : ((mag + half) >> AMT_FRAC);
		return v[PW-1] ? -signed'(q) : signed'(q);
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(input logic signed [W-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[FIELD_W-1:0];
	endfunction

	logic signed [FIELD_W-1:0] coef_q [NCOEF];
	logic [AMT_W-1:0]          amt_q, gain_q;
	logic [AXIS_W-1:0]         axis_q;
	logic                      first_q;
	logic signed [W-1:0]       p_q [3];
	logic signed [W-1:0]       g_q [3];
	logic signed [W-1:0]       w_q [3];
	logic signed [W-1:0]       min_q, max_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [PW-1:0]      prod_s1;
	logic signed [W:0]         d_q, span_q;
	logic [F:0]                h_q;
	logic [W+1:0]              r_q;
	logic [F+1:0]              s_q;
	logic                      out_valid_q;
	logic [FIELD_W-1:0]        out_x_q, out_y_q, out_z_q;

	logic [IDX_W-1:0]          rd_addr;
	logic signed [FIELD_W-1:0] coef_rd;
	logic [1:0]                ax, aa, ab;
	logic signed [W-1:0]       vec;
	logic signed [W:0]         d_now, span_now;
	logic signed [M-1:0]       ma, mb;
	logic signed [PW-1:0]      rnd_f, rnd_a;
	logic signed [AW-1:0]      sum_last, g_drop;
	logic [PW-1:0]             s_full;
	logic [W+1:0]              r2, span_u;

	assign rd_addr = (cmd.inv ? IDX_W'(INV_BASE) : '0) + {1'b0, cmd.row, cmd.col};
	assign coef_rd = coef_q[rd_addr];

	always_comb begin
		case (axis_q)
			2'd0:    ax = 2'd0;
			2'd1:    ax = 2'd1;
			default: ax = 2'd2;
		endcase
		aa = (ax == 2'd0) ? 2'd1 : 2'd0;
		ab = (ax == 2'd2) ? 2'd1 : 2'd2;
	end

	always_comb begin
		case (cmd.col)
			2'd0:    vec = cmd.inv ? g_q[0] : p_q[0];
			2'd1:    vec = cmd.inv ? g_q[1] : p_q[1];
			default: vec = cmd.inv ? g_q[2] : p_q[2];
		endcase
	end

	assign d_now    = (W+1)'(g_q[ax]) - (W+1)'(min_q);
	assign span_now = (W+1)'(max_q) - (W+1)'(min_q);

	always_comb begin
		case (cmd.mul_a)
			MA_COEF: ma = M'(coef_rd);
			MA_D:    ma = M'(d_now);
			MA_H:    ma = signed'(M'(h_q));
			MA_T:    ma = M'(prod_s1 >>> F);
			MA_G_A:  ma = M'(g_q[aa]);
			MA_G_B:  ma = M'(g_q[ab]);
			default: ma = '0;
		endcase
		case (cmd.mul_b)
			MB_VEC:         mb = M'(vec);
			MB_AMT:         mb = signed'(M'(amt_q));
			MB_ONE_MINUS_H: mb = signed'(M'(ONE_H - h_q));
			MB_GAIN:        mb = signed'(M'(gain_q));
			MB_S:           mb = signed'(M'(s_q));
			default:        mb = '0;
		endcase
	end

	assign rnd_f    = rnd(prod_s1, HALF_F, 1'b1);
	assign rnd_a    = rnd(prod_s1, HALF_A, 1'b0);
	assign sum_last = acc_q + AW'(rnd_f) + AW'(coef_rd);
	assign g_drop   = AW'(g_q[ax]) - AW'(rnd_a);
	assign s_full   = PW'(ONE_H) + $unsigned(prod_s1 >>> AMT_FRAC);
	assign r2       = r_q << 1;
	assign span_u   = $unsigned((W+2)'(span_q));

	assign sts.pass      = (amt_q == '0) || (span_now <= THR);
	assign sts.d_le0     = (d_q <= 0);
	assign sts.d_ge_span = (d_q >= span_q);
	assign sts.gain_zero = (gain_q == '0);
	assign sts.out_full  = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.coef_wr && (coef_index < IDX_W'(NCOEF))) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amt_q  <= '0;
			gain_q <= '0;
			axis_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AMOUNT: amt_q  <= cfg_data;
				CFG_SPREAD: gain_q <= cfg_data;
				CFG_AXIS:   axis_q <= cfg_data[AXIS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= HI_W;
			max_q <= LO_W;
		end else if (cmd.meas) begin
			if (first_q) begin
				min_q <= g_q[ax];
				max_q <= g_q[ax];
			end else begin
				if (g_q[ax] < min_q) begin
					min_q <= g_q[ax];
				end
				if (g_q[ax] > max_q) begin
					max_q <= g_q[ax];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q <= first_vertex;
			p_q[0]  <= clamp_w(AW'(pos_x));
			p_q[1]  <= clamp_w(AW'(pos_y));
			p_q[2]  <= clamp_w(AW'(pos_z));
		end
		if (cmd.mul_en) begin
			prod_s1 <= ma * mb;
		end
		case (cmd.post)
			PO_ACC_INIT: acc_q <= AW'(rnd_f);
			PO_ACC_ADD:  acc_q <= acc_q + AW'(rnd_f);
			PO_ACC_LAST: begin
				if (cmd.inv) begin
					w_q[cmd.row] <= clamp_w(sum_last);
				end else begin
					g_q[cmd.row] <= clamp_w(sum_last);
				end
			end
			PO_DROP: g_q[ax] <= clamp_w(g_drop);
			PO_S:    s_q <= s_full[F+1:0];
			PO_G_A:  g_q[aa] <= clamp_w(AW'(rnd_f));
			PO_G_B:  g_q[ab] <= clamp_w(AW'(rnd_f));
			default: begin
			end
		endcase
		if (cmd.check) begin
			d_q    <= d_now;
			span_q <= span_now;
			if (sts.pass) begin
				w_q[0] <= p_q[0];
				w_q[1] <= p_q[1];
				w_q[2] <= p_q[2];
			end
		end
		if (cmd.div_init) begin
			h_q <= sts.d_le0 ? '0 : (sts.d_ge_span ? ONE_H : '0);
			r_q <= $unsigned((W+2)'(d_q));
		end else if (cmd.div_step) begin
			if (r2 >= span_u) begin
				r_q <= r2 - span_u;
				h_q <= {h_q[F-1:0], 1'b1};
			end else begin
				r_q <= r2;
				h_q <= {h_q[F-1:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_x_q <= to_field(w_q[0]);
			out_y_q <= to_field(w_q[1]);
			out_z_q <= to_field(w_q[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = signed'(out_x_q);
	assign out_y     = signed'(out_y_q);
	assign out_z     = signed'(out_z_q);
endmodule

/* hdl/melt_vertex_deform.sv */
// Coefficient write: taken in the idle state. Measure item: the twelve shared-multiplier
// steps of the forward transform, then the height update. Deform item: the vertex either
// passes unchanged, or is deformed without spreading, with spreading at a clamped height, or
// with spreading after the one-bit-per-cycle divider forms the height ratio. A deform stalls in
// its output state while the output register still holds an untaken result. Reset is asynchronous,
// active low: min and max height and the settings return to defaults, coefficients do not.
module melt_vertex_deform #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mvd_req_if.sink                          req,
	mvd_res_if.source                        res,
	input  logic                             cfg_we,
	input  logic [mvd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mvd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mvd_pkg::*;

	// Command and status between the sequencer and the datapath.
	cmd_t cmd;
	sts_t sts;

	// The sequencer walks each transform as four steps per row: three products issued
	// on the shared multiplier, then the translation added as the last product lands.
	mvd_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_req   (req.req_type),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the coefficients, settings, height tracking, the multiplier with
	// its product register, the rounding adder and the restoring divider for the height
	// ratio. A result transfer frees the output register.
	mvd_datapath #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.coef_index   (req.coef_index),
		.coef_value   (req.coef_value),
		.first_vertex (req.first_vertex),
		.pos_x        (req.pos_x),
		.pos_y        (req.pos_y),
		.pos_z        (req.pos_z),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.out_valid    (res.valid),
		.out_ready    (res.ready),
		.out_x        (res.out_x),
		.out_y        (res.out_y),
		.out_z        (res.out_z)
	);

	// A result is only loaded into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("result loaded over a pending transfer");

	// A loaded result is offered in the next cycle.
	a_load_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> res.valid)
		else $error("loaded result not offered");

	// While the block waits for an item, no arithmetic is in flight.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!cmd.mul_en && cmd.post == PO_NONE && !cmd.div_step))
		else $error("datapath busy while idle");

	// The divider only steps after it was seeded.
	a_div_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !$past(cmd.div_step)) |-> $past(cmd.div_init))
		else $error("divider stepped without seed");
endmodule
